[sv/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes for the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int WORD_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;

    // Request mode codes as seen on the input stream
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DUMP       = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

    // Decoded operation
    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_POP_FRONT,
        OP_PUSH_REAR,
        OP_POP_REAR,
        OP_DUMP,
        OP_BAD
    } t_op;

    // Classified request held in the queue between front and back
    typedef struct packed {
        t_op                       op;
        logic signed [WORD_W-1:0]  value;
    } t_req;

endpackage

[sv/bdq_ram.sv]
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/bdq_front.sv]
// ----------------------------------------------------------------------------
// bdq_front
// Accepts requests, decodes the mode and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module bdq_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [bdq_pkg::MODE_W-1:0]         i_mode,
    input  logic signed [bdq_pkg::WORD_W-1:0]  i_value,
    output logic                               o_q_valid,
    output bdq_pkg::t_req                      o_q_req,
    input  logic                               i_q_pop
);

    import bdq_pkg::*;

    t_req       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_req       dec_req;
    logic       push;

    always_comb begin
        dec_req.value = i_value;
        unique case (i_mode)
            MODE_PUSH_FRONT: dec_req.op = OP_PUSH_FRONT;
            MODE_POP_FRONT:  dec_req.op = OP_POP_FRONT;
            MODE_PUSH_REAR:  dec_req.op = OP_PUSH_REAR;
            MODE_POP_REAR:   dec_req.op = OP_POP_REAR;
            MODE_DUMP:       dec_req.op = OP_DUMP;
            default:         dec_req.op = OP_BAD;
        endcase
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_req   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec_req;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

endmodule

[sv/bdq_back.sv]
// ----------------------------------------------------------------------------
// bdq_back
// Executes queued requests against the circular store and drives results.
// ----------------------------------------------------------------------------
module bdq_back #(
    parameter int DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  bdq_pkg::t_req                        i_q_req,
    output logic                                 o_q_pop,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [bdq_pkg::STATUS_W-1:0]         o_status,
    output logic signed [bdq_pkg::WORD_W-1:0]    o_data,
    output logic                                 o_last
);

    import bdq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {S_RUN, S_DUMP} t_state;

    // pending result: issued to the RAM, read data arrives next cycle
    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic                last;
        logic                use_ram;
    } t_pend;

    t_state  r_state, n_state;
    logic [IW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_off, n_off;
    t_pend   r_p, n_p;

    logic                r_o_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [WORD_W-1:0]   r_o_data;
    logic                r_o_last;

    logic              ram_we, ram_re;
    logic [IW-1:0]     ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic          p_move, advance, full, empty, dump_last;
    logic [CW-1:0] cnt_m1;
    logic [IW-1:0] front_dec, front_inc;

    function automatic logic [IW-1:0] slot(input logic [IW-1:0] base,
                                           input logic [IW-1:0] off);
        logic [IW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IW+1)'(DEPTH)) begin
            sum = sum - (IW+1)'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    bdq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_q_req.value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign p_move    = r_p.valid && (!r_o_valid || i_ready);
    assign advance   = !r_p.valid || p_move;
    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign cnt_m1    = r_count - 1'b1;
    assign dump_last = ((CW'(r_off) + 1'b1) == r_count);
    assign front_dec = (r_front == '0) ? IW'(DEPTH - 1) : r_front - 1'b1;
    assign front_inc = (r_front == IW'(DEPTH - 1)) ? '0 : r_front + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_front   = r_front;
        n_count   = r_count;
        n_off     = r_off;
        n_p       = r_p;
        n_p.valid = r_p.valid && !p_move;
        o_q_pop   = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_front;
        ram_raddr = r_front;
        if (advance) begin
            unique case (r_state)
                S_DUMP: begin
                    ram_re      = 1'b1;
                    ram_raddr   = slot(r_front, r_off);
                    n_p.valid   = 1'b1;
                    n_p.status  = ST_OK;
                    n_p.use_ram = 1'b1;
                    n_p.last    = dump_last;
                    n_off       = r_off + 1'b1;
                    if (dump_last) begin
                        n_state = S_RUN;
                    end
                end
                S_RUN: begin
                    if (i_q_valid) begin
                        o_q_pop     = 1'b1;
                        n_p.valid   = 1'b1;
                        n_p.status  = ST_OK;
                        n_p.use_ram = 1'b0;
                        n_p.last    = 1'b1;
                        unique case (i_q_req.op)
                            OP_PUSH_FRONT: begin
                                if (full) begin
                                    n_p.status = ST_FULL;
                                end else begin
                                    ram_we    = 1'b1;
                                    ram_waddr = front_dec;
                                    n_front   = front_dec;
                                    n_count   = r_count + 1'b1;
                                end
                            end
                            OP_PUSH_REAR: begin
                                if (full) begin
                                    n_p.status = ST_FULL;
                                end else begin
                                    ram_we    = 1'b1;
                                    ram_waddr = slot(r_front, r_count[IW-1:0]);
                                    n_count   = r_count + 1'b1;
                                end
                            end
                            OP_POP_FRONT: begin
                                if (empty) begin
                                    n_p.status = ST_EMPTY;
                                end else begin
                                    ram_re      = 1'b1;
                                    ram_raddr   = r_front;
                                    n_p.use_ram = 1'b1;
                                    n_front     = front_inc;
                                    n_count     = cnt_m1;
                                end
                            end
                            OP_POP_REAR: begin
                                if (empty) begin
                                    n_p.status = ST_EMPTY;
                                end else begin
                                    ram_re      = 1'b1;
                                    ram_raddr   = slot(r_front, cnt_m1[IW-1:0]);
                                    n_p.use_ram = 1'b1;
                                    n_count     = cnt_m1;
                                end
                            end
                            OP_DUMP: begin
                                if (empty) begin
                                    n_p.status = ST_EMPTY;
                                end else begin
                                    ram_re      = 1'b1;
                                    ram_raddr   = r_front;
                                    n_p.use_ram = 1'b1;
                                    n_p.last    = (r_count == CW'(1));
                                    n_off       = IW'(1);
                                    if (r_count != CW'(1)) begin
                                        n_state = S_DUMP;
                                    end
                                end
                            end
                            default: begin
                                n_p.status = ST_INVALID;
                            end
                        endcase
                    end
                end
                default: begin
                    n_state = S_RUN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_off           <= n_off;
        r_p.status      <= n_p.status;
        r_p.last        <= n_p.last;
        r_p.use_ram     <= n_p.use_ram;
        if (p_move) begin
            r_o_status <= r_p.status;
            r_o_data   <= r_p.use_ram ? ram_rdata : '0;
            r_o_last   <= r_p.last;
        end
        if (!i_rst_n) begin
            r_state   <= S_RUN;
            r_front   <= '0;
            r_count   <= '0;
            r_p.valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_front   <= n_front;
            r_count   <= n_count;
            r_p.valid <= n_p.valid;
            if (p_move) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_o_valid;
    assign o_status = r_o_status;
    assign o_data   = r_o_data;
    assign o_last   = r_o_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front < IW'(DEPTH - 1) || r_front == IW'(DEPTH - 1))
        else $error("front index out of range");

    a_dump_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DUMP |-> (CW'(r_off) < r_count) && !o_q_pop)
        else $error("dump offset past rear or queue popped during dump");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid && advance)
        else $error("queue popped while empty or stalled");

    a_pend_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p.valid && !p_move |=> r_p.valid && $stable(r_p.status))
        else $error("stalled pending result lost");

endmodule

[sv/bounded_deque_top.sv]
// ----------------------------------------------------------------------------
// bounded_deque_top
// Bounded double-ended queue of signed 32-bit words on stream interfaces.
// Each input request carries a mode in tuser (push front, pop front, push
// rear, pop rear, dump; other codes report invalid) and a value in tdata.
// Push, pop and invalid requests give one result each, so they sustain one
// request per clock while the output is not stalled. A dump walks the stored
// entries from front to rear, one result per cycle while the output is not
// stalled, and holds the execution unit until its last result is issued; the
// rate is set by the single read port of the entry RAM. From input handshake
// to result a request passes the queue, the RAM read and the output register.
// Results carry the status in tuser, the popped or dumped value in tdata
// (zero otherwise) and tlast on the final result of each request. Push onto
// a full store reports full, pop or dump on an empty store reports empty,
// and the store is left unchanged in those cases. A two-entry request queue
// separates decode from execution so either side can stall on its own.
// ----------------------------------------------------------------------------
module bounded_deque_top #(
    parameter int DEPTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [bdq_pkg::WORD_W-1:0]          i_s_axis_tdata,  // [31:0] value
    input  logic [bdq_pkg::MODE_W-1:0]          i_s_axis_tuser,  // [2:0] mode
    // result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [bdq_pkg::WORD_W-1:0]          o_m_axis_tdata,  // [31:0] data
    output logic [bdq_pkg::STATUS_W-1:0]        o_m_axis_tuser,  // [1:0] status
    output logic                                o_m_axis_tlast
);

    import bdq_pkg::*;

    logic q_valid;
    t_req q_req;
    logic q_pop;

    // front: accept and classify requests
    bdq_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_mode    (i_s_axis_tuser),
        .i_value   (i_s_axis_tdata),
        .o_q_valid (q_valid),
        .o_q_req   (q_req),
        .i_q_pop   (q_pop)
    );

    // back: store, pointers, dump sequencer and output register
    bdq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_req   (q_req),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_status  (o_m_axis_tuser),
        .o_data    (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast)
    );

endmodule

[tb/tb_bounded_deque_top.sv]
// ----------------------------------------------------------------------------
// tb_bounded_deque_top
// Self-checking testbench for the bounded deque on its stream interfaces.
// A behavioural copy of the deque, updated at each accepted request, queues
// the results it expects. A checker compares every result taken from the
// output stream, field by field, against the oldest expectation. Named test
// tasks cover empty and full handling, invalid modes, field extremes, a long
// output stall that backs up the input, and random mixed traffic. Both
// streams idle at random in some of the tests.
// ----------------------------------------------------------------------------
module tb_bounded_deque_top;

    import bdq_pkg::*;

    localparam int DEPTH        = 32;
    localparam int CYCLE_LIMIT  = 1_500_000;  // far above the slowest legal run
    localparam int DRAIN_CYCLES = 12;         // pipeline is three deep, with margin
    localparam int HOLD_CYCLES  = 200;        // long output stall

    // Mode codes past dump are all reported invalid
    localparam logic [MODE_W-1:0] MODE_BAD_FIRST = MODE_DUMP + 3'd1;
    localparam logic [MODE_W-1:0] MODE_BAD_LAST  = '1;

    localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   data;
        logic                last;
    } t_result;

    // ------------------------------------------------------------------
    // Clock, reset and DUT connections
    // ------------------------------------------------------------------
    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_valid = 1'b0;
    logic [WORD_W-1:0]   s_value = '0;
    logic [MODE_W-1:0]   s_mode  = '0;
    logic                m_ready = 1'b0;
    logic                o_s_axis_tready;
    logic                o_m_axis_tvalid;
    logic [WORD_W-1:0]   o_m_axis_tdata;
    logic [STATUS_W-1:0] o_m_axis_tuser;
    logic                o_m_axis_tlast;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    bounded_deque_top #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_value),         // [31:0] value
        .i_s_axis_tuser  (s_mode),          // [2:0] mode
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // [31:0] data
        .o_m_axis_tuser  (o_m_axis_tuser),  // [1:0] status
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // Shadow deque and expected results
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] deque_words [DEPTH];
    int                deque_front = 0;
    int                deque_count = 0;
    t_result           pending_results [$];
    t_result           want_result;
    int                error_count = 0;

    // Idle percentages per side; the tests change them between phases
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // Long stall: a test bumps the token, the ready process counts it out
    int hold_token_req  = 0;
    int hold_token_seen = 0;
    int hold_left       = 0;
    int stall_left      = 0;
    int rx_gap;
    int cycle_count     = 0;

    // Gap with the given percentage chance; short ones often, a long one now and then
    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(30, 8);
        return $urandom_range(3, 1);
    endfunction

    // Random word, with the extremes turning up more often than chance
    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(15))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Apply one accepted request to the shadow deque and queue its results
    task automatic predict_deque_op(input logic [MODE_W-1:0] mode,
                                    input logic [WORD_W-1:0] value);
        int slot;
        int i;
        case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
                if (deque_count == DEPTH) begin
                    pending_results.push_back('{ST_FULL, '0, 1'b1});
                end else begin
                    if (mode == MODE_PUSH_FRONT) begin
                        deque_front = (deque_front + DEPTH - 1) % DEPTH;
                        slot = deque_front;
                    end else begin
                        slot = (deque_front + deque_count) % DEPTH;
                    end
                    deque_words[slot] = value;
                    deque_count++;
                    pending_results.push_back('{ST_OK, '0, 1'b1});
                end
            end
            MODE_POP_FRONT, MODE_POP_REAR: begin
                if (deque_count == 0) begin
                    pending_results.push_back('{ST_EMPTY, '0, 1'b1});
                end else begin
                    if (mode == MODE_POP_FRONT) begin
                        slot = deque_front;
                        deque_front = (deque_front + 1) % DEPTH;
                    end else begin
                        slot = (deque_front + deque_count - 1) % DEPTH;
                    end
                    deque_count--;
                    pending_results.push_back('{ST_OK, deque_words[slot], 1'b1});
                end
            end
            MODE_DUMP: begin
                if (deque_count == 0) begin
                    pending_results.push_back('{ST_EMPTY, '0, 1'b1});
                end else begin
                    for (i = 0; i < deque_count; i++) begin
                        pending_results.push_back('{ST_OK,
                            deque_words[(deque_front + i) % DEPTH],
                            logic'(i == deque_count - 1)});
                    end
                end
            end
            default: begin
                pending_results.push_back('{ST_INVALID, '0, 1'b1});
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request side: offer one request, hold it until taken
    // ------------------------------------------------------------------
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic [WORD_W-1:0] value);
        int gap;
        gap = pick_gap(tx_idle_pct);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_value <= value;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_deque_op(mode, value);
    endtask

    // Sender goes quiet until every expected result has been taken
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: ready with random stalls, plus the long hold
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_token_seen != hold_token_req) begin
            hold_token_seen <= hold_token_req;
            hold_left       <= HOLD_CYCLES;
            m_ready         <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            rx_gap = pick_gap(rx_idle_pct);
            if (rx_gap > 0) begin
                stall_left <= rx_gap - 1;
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each taken result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: status %0d data %h last %b", $time,
                         o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast);
                error_count++;
            end else begin
                want_result = pending_results.pop_front();
                if (o_m_axis_tuser !== want_result.status) begin
                    $display("%0t: status mismatch: expected %0d got %0d", $time,
                             want_result.status, o_m_axis_tuser);
                    error_count++;
                end
                if (o_m_axis_tdata !== want_result.data) begin
                    $display("%0t: data mismatch: expected %h got %h", $time,
                             want_result.data, o_m_axis_tdata);
                    error_count++;
                end
                if (o_m_axis_tlast !== want_result.last) begin
                    $display("%0t: last mismatch: expected %b got %b", $time,
                             want_result.last, o_m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty handling, invalid codes, value extremes, every operation
    task automatic test_directed_cases();
        int bad;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_request(MODE_POP_FRONT, random_word());
        send_request(MODE_POP_REAR, random_word());
        send_request(MODE_DUMP, random_word());
        for (bad = int'(MODE_BAD_FIRST); bad <= int'(MODE_BAD_LAST); bad++)
            send_request(MODE_W'(bad), random_word());
        send_request(MODE_PUSH_FRONT, WORD_MIN);
        send_request(MODE_PUSH_REAR, WORD_MAX);
        send_request(MODE_PUSH_FRONT, '1);
        send_request(MODE_PUSH_REAR, '0);
        send_request(MODE_DUMP, '1);
        send_request(MODE_POP_FRONT, '0);
        send_request(MODE_POP_REAR, '1);
        send_request(MODE_DUMP, '0);
        send_request(MODE_POP_FRONT, random_word());
        send_request(MODE_POP_REAR, random_word());
        send_request(MODE_DUMP, random_word());
        wait_for_results();
    endtask

    // Fill to capacity from both ends, push past full, dump all, drain
    task automatic test_full_store();
        int i;
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        while (deque_count > 0) send_request(MODE_POP_FRONT, random_word());
        for (i = 0; i < DEPTH; i++)
            send_request(i[0] ? MODE_PUSH_REAR : MODE_PUSH_FRONT, random_word());
        send_request(MODE_PUSH_FRONT, random_word());
        send_request(MODE_PUSH_REAR, random_word());
        send_request(MODE_DUMP, random_word());
        send_request(MODE_BAD_LAST, random_word());
        for (i = 0; i < DEPTH; i++)
            send_request(i[0] ? MODE_POP_REAR : MODE_POP_FRONT, random_word());
        send_request(MODE_POP_REAR, random_word());
        wait_for_results();
    endtask

    // Output held off for a long stretch while requests keep coming;
    // the request queue fills and input ready must drop
    task automatic test_stalled_output();
        int i;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_token_req <= hold_token_req + 1;
        for (i = 0; i < 12; i++) send_request(MODE_PUSH_REAR, random_word());
        send_request(MODE_DUMP, random_word());
        for (i = 0; i < 6; i++) send_request(MODE_PUSH_FRONT, random_word());
        send_request(MODE_DUMP, random_word());
        for (i = 0; i < 6; i++)
            send_request(i[0] ? MODE_POP_FRONT : MODE_POP_REAR, random_word());
        wait_for_results();
    endtask

    // Mixed traffic in chunks; each chunk leans towards filling, emptying
    // or neither, and picks its own idling on each side
    task automatic test_random_traffic(input int n_requests);
        int i;
        int r;
        int push_pct;
        int idle_choice [3] = '{0, 25, 60};
        for (i = 0; i < n_requests; i++) begin
            if (i % 25 == 0) begin
                case ($urandom_range(2))
                    0:       push_pct = 75;
                    1:       push_pct = 30;
                    default: push_pct = 50;
                endcase
                tx_idle_pct = idle_choice[$urandom_range(2)];
                rx_idle_pct = idle_choice[$urandom_range(2)];
            end
            r = $urandom_range(99);
            if (r < push_pct)
                send_request($urandom_range(1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT,
                             random_word());
            else if (r < 92)
                send_request($urandom_range(1) ? MODE_POP_REAR : MODE_POP_FRONT,
                             random_word());
            else if (r < 97)
                send_request(MODE_DUMP, random_word());
            else
                send_request(MODE_W'($urandom_range(MODE_BAD_LAST, MODE_BAD_FIRST)),
                             random_word());
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_full_store();
        test_stalled_output();
        test_random_traffic(150);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[bounded_deque_top.f]
sv/bdq_pkg.sv
sv/bdq_ram.sv
sv/bdq_front.sv
sv/bdq_back.sv
sv/bounded_deque_top.sv
tb/tb_bounded_deque_top.sv
